// ===== rtl/hs_pkg.sv =====
// hs_pkg: shared types, constants and helpers of the HMAC-SHA1 engine.
// No dependencies; imported by every module in rtl/.
package hs_pkg;

  localparam int BLOCK_BYTES     = 64;
  localparam int DIGEST_BYTES    = 20;
  localparam int DIGEST_WORDS    = DIGEST_BYTES / 4;
  localparam int LEN_BYTES       = 8;
  localparam int ROUNDS          = 80;
  localparam int LENGTH_BITS_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0] IPAD     = 8'h36;
  localparam logic [7:0] OPAD     = 8'h5c;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'(BLOCK_BYTES - LEN_BYTES);

  typedef logic [31:0] word_t;
  typedef logic [DIGEST_WORDS-1:0][31:0] digest_t;

  localparam digest_t SHA_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  typedef struct packed {
    logic       msg;
    logic [7:0] data;
    logic       valid;
    logic       last;
  } op_t;

  typedef struct packed {
    logic       init;
    logic       push;
    logic [7:0] data;
  } sha_ctrl_t;

  typedef struct packed {
    logic       ready;
    logic [5:0] bpos;
  } sha_stat_t;

  function automatic logic [7:0] byte_of(word_t w, logic [1:0] lane);
    logic [7:0] b;
    case (lane)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/hmac_sha1_engine.sv =====
// hmac_sha1_engine: streaming HMAC-SHA1 top level.
// Depends on hs_pkg, hs_front, hs_queue, hs_sha, hs_back.
//
//   channel   handshake         payload
//   input     push / full       cmd, data_byte, byte_valid, last_of_part
//   result    empty / pop       digest_word, word_index, last_word, length_overflow
//
// Bytes pass through the sequencer one at a time; every 64th byte of a
// SHA-1 stream starts a compression in the single-round compression unit.
// Closing the key loads the inner pad block, after a SHA-1 finish when the key
// was hashed; the message end finishes both hashes before the first word.
// Reset is synchronous and clears all control state.
// A 4-entry op queue keeps taking words while the sequencer or output stalls.
module hmac_sha1_engine import hs_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        last_of_part,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        length_overflow
);

  logic      q_full;
  logic      q_push;
  op_t       q_in;
  logic      q_empty;
  logic      q_pop;
  op_t       q_out;
  sha_ctrl_t sctrl;
  sha_stat_t sstat;
  digest_t   hash;

  hs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .last_of_part (last_of_part),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_op         (q_in)
  );

  hs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  hs_sha u_sha (
    .clk  (clk),
    .rst  (rst),
    .ctrl (sctrl),
    .stat (sstat),
    .hash (hash)
  );

  hs_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_op            (q_out),
    .sctrl           (sctrl),
    .sstat           (sstat),
    .hash            (hash),
    .empty           (empty),
    .pop             (pop),
    .digest_word     (digest_word),
    .word_index      (word_index),
    .last_word       (last_word),
    .length_overflow (length_overflow)
  );

endmodule

// ===== rtl/hs_front.sv =====
// hs_front: accepts input words, drops key bytes that arrive after the key
// has closed, and tracks the key/message phase. Depends on hs_pkg.
module hs_front import hs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       cmd,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       last_of_part,
  input  logic       q_full,
  output logic       q_push,
  output op_t        q_op
);

  logic msg_phase;
  logic keep;

  assign keep   = cmd | ~msg_phase;
  assign full   = q_full;
  assign q_push = push & ~q_full & keep;
  assign q_op   = '{msg: cmd, data: data_byte, valid: byte_valid, last: last_of_part};

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_phase <= 1'b0;
    end else if (q_push) begin
      if (cmd) begin
        msg_phase <= ~last_of_part;
      end else if (last_of_part) begin
        msg_phase <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/hs_queue.sv =====
// hs_queue: short op queue between front and back.
// Depends on hs_pkg.
module hs_queue import hs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  din,
  output logic full,
  input  logic pop,
  output op_t  dout,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);

  op_t           mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == (AW+1)'(DEPTH);
  assign empty   = count == '0;
  assign dout    = mem[rp];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/hs_sha.sv =====
// hs_sha: SHA-1 byte packer and compression unit, one round per cycle.
// Depends on hs_pkg.
module hs_sha import hs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  sha_ctrl_t ctrl,
  output sha_stat_t stat,
  output digest_t   hash
);

  word_t       w [16];
  logic [23:0] cur;
  word_t       a, b, c, d, e;
  logic [6:0]  rnd;
  logic        busy;
  logic [5:0]  bpos;
  word_t       f, k, wnew, t2;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    wnew = w[13] ^ w[8] ^ w[2] ^ w[0];
    wnew = {wnew[30:0], wnew[31]};
    t2   = {a[26:0], a[31:27]} + f + e + k + w[0];
  end

  assign stat.ready = ~busy;
  assign stat.bpos  = bpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bpos <= '0;
      rnd  <= '0;
    end else begin
      if (ctrl.init) begin
        hash <= SHA_IV;
      end
      if (busy) begin
        if (rnd == 7'(ROUNDS)) begin
          hash[0] <= hash[0] + a;
          hash[1] <= hash[1] + b;
          hash[2] <= hash[2] + c;
          hash[3] <= hash[3] + d;
          hash[4] <= hash[4] + e;
          busy    <= 1'b0;
        end else begin
          a <= t2;
          b <= a;
          c <= {b[1:0], b[31:2]};
          d <= c;
          e <= d;
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= wnew;
          rnd   <= rnd + 1'b1;
        end
      end else if (ctrl.push) begin
        cur  <= {cur[15:0], ctrl.data};
        bpos <= bpos + 1'b1;
        if (bpos[1:0] == 2'd3) begin
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= {cur, ctrl.data};
        end
        if (bpos == 6'(BLOCK_BYTES - 1)) begin
          busy <= 1'b1;
          rnd  <= '0;
          a    <= hash[0];
          b    <= hash[1];
          c    <= hash[2];
          d    <= hash[3];
          e    <= hash[4];
        end
      end
    end
  end

endmodule

// ===== rtl/hs_back.sv =====
// hs_back: HMAC sequencer; key handling, pads, SHA-1 finishing and digest
// output register. Depends on hs_pkg; drives hs_sha.
module hs_back import hs_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  output logic        q_pop,
  input  op_t         q_op,
  output sha_ctrl_t   sctrl,
  input  sha_stat_t   sstat,
  input  digest_t     hash,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        length_overflow
);

  localparam logic [LENGTH_BITS-1:0] LIMIT = '1;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_KEY, S_HKEY, S_KCLOSE, S_F80, S_FZ, S_FLEN, S_FWAIT,
    S_KCOPY, S_PADINIT, S_PADS, S_MSG, S_MEND, S_SAVEIN, S_INNER, S_EMIT, S_CLEAR
  } state_t;

  state_t                 state;
  state_t                 fin_ret;
  op_t                    op;
  logic [LENGTH_BITS-1:0] plen;
  logic                   hashed;
  logic                   ovf;
  logic                   key_phase;
  logic                   outer;
  logic [5:0]             cnt;
  logic [63:0]            lenreg;
  word_t                  key_w [16];
  digest_t                inner;
  logic                   out_valid;
  logic                   at_limit;
  logic                   short_key;
  logic [LENGTH_BITS:0]   msg_total;
  logic [7:0]             key_byte;

  assign at_limit  = plen == LIMIT;
  assign short_key = plen < LENGTH_BITS'(BLOCK_BYTES);
  assign msg_total = {1'b0, plen} + (LENGTH_BITS+1)'(BLOCK_BYTES);
  assign key_byte  = byte_of(key_w[cnt[5:2]], cnt[1:0]);
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign empty     = ~out_valid;

  always_comb begin
    sctrl = '0;
    unique case (state)
      S_KEY: begin
        if (!at_limit && !short_key) begin
          if (!hashed) begin
            sctrl.init = sstat.ready;
          end else begin
            sctrl.push = sstat.ready;
            sctrl.data = op.data;
          end
        end
      end
      S_HKEY: begin
        sctrl.push = sstat.ready;
        sctrl.data = key_byte;
      end
      S_F80: begin
        sctrl.push = sstat.ready;
        sctrl.data = PAD_MARK;
      end
      S_FZ: begin
        sctrl.push = sstat.ready && (sstat.bpos != LEN_POS);
      end
      S_FLEN: begin
        sctrl.push = sstat.ready;
        sctrl.data = lenreg[63:56];
      end
      S_PADINIT: begin
        sctrl.init = sstat.ready;
      end
      S_PADS: begin
        sctrl.push = sstat.ready;
        sctrl.data = key_byte ^ (outer ? OPAD : IPAD);
      end
      S_MSG: begin
        sctrl.push = sstat.ready && op.valid && !at_limit;
        sctrl.data = op.data;
      end
      S_INNER: begin
        sctrl.push = sstat.ready;
        sctrl.data = byte_of(inner[cnt[4:2]], cnt[1:0]);
      end
      default: begin
        sctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fin_ret   <= S_IDLE;
      out_valid <= 1'b0;
      plen      <= '0;
      hashed    <= 1'b0;
      ovf       <= 1'b0;
      key_phase <= 1'b1;
      outer     <= 1'b0;
      cnt       <= '0;
      for (int i = 0; i < 16; i++) begin
        key_w[i] <= '0;
      end
    end else begin
      if (pop && out_valid && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            op    <= q_op;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (op.msg) begin
            state <= key_phase ? S_KCLOSE : S_MSG;
          end else if (op.valid) begin
            state <= S_KEY;
          end else if (op.last) begin
            state <= S_KCLOSE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_KEY: begin
          if (at_limit) begin
            ovf   <= 1'b1;
            state <= op.last ? S_KCLOSE : S_IDLE;
          end else if (short_key) begin
            case (plen[1:0])
              2'd0:    key_w[plen[5:2]][31:24] <= op.data;
              2'd1:    key_w[plen[5:2]][23:16] <= op.data;
              2'd2:    key_w[plen[5:2]][15:8]  <= op.data;
              default: key_w[plen[5:2]][7:0]   <= op.data;
            endcase
            plen  <= plen + 1'b1;
            state <= op.last ? S_KCLOSE : S_IDLE;
          end else if (sctrl.init) begin
            hashed <= 1'b1;
            cnt    <= '0;
            state  <= S_HKEY;
          end else if (sctrl.push) begin
            plen  <= plen + 1'b1;
            state <= op.last ? S_KCLOSE : S_IDLE;
          end
        end
        S_HKEY: begin
          if (sctrl.push) begin
            cnt <= cnt + 1'b1;
            if (cnt == 6'(BLOCK_BYTES - 1)) begin
              state <= S_KEY;
            end
          end
        end
        S_KCLOSE: begin
          if (hashed) begin
            lenreg  <= 64'(plen) << 3;
            fin_ret <= S_KCOPY;
            state   <= S_F80;
          end else begin
            state <= S_PADINIT;
          end
        end
        S_F80: begin
          if (sctrl.push) begin
            state <= S_FZ;
          end
        end
        S_FZ: begin
          if (sstat.bpos == LEN_POS) begin
            cnt   <= '0;
            state <= S_FLEN;
          end
        end
        S_FLEN: begin
          if (sctrl.push) begin
            lenreg <= lenreg << 8;
            cnt    <= cnt + 1'b1;
            if (cnt == 6'(LEN_BYTES - 1)) begin
              state <= S_FWAIT;
            end
          end
        end
        S_FWAIT: begin
          if (sstat.ready) begin
            cnt   <= '0;
            state <= fin_ret;
          end
        end
        S_KCOPY: begin
          for (int i = 0; i < 16; i++) begin
            key_w[i] <= (i < DIGEST_WORDS) ? hash[i] : '0;
          end
          state <= S_PADINIT;
        end
        S_PADINIT: begin
          if (sctrl.init) begin
            cnt   <= '0;
            state <= S_PADS;
          end
        end
        S_PADS: begin
          if (sctrl.push) begin
            cnt <= cnt + 1'b1;
            if (cnt == 6'(BLOCK_BYTES - 1)) begin
              if (outer) begin
                state <= S_INNER;
              end else begin
                plen      <= '0;
                key_phase <= 1'b0;
                state     <= op.msg ? S_MSG : S_IDLE;
              end
            end
          end
        end
        S_MSG: begin
          if (op.valid && at_limit) begin
            ovf   <= 1'b1;
            state <= op.last ? S_MEND : S_IDLE;
          end else if (!op.valid) begin
            state <= op.last ? S_MEND : S_IDLE;
          end else if (sctrl.push) begin
            plen  <= plen + 1'b1;
            state <= op.last ? S_MEND : S_IDLE;
          end
        end
        S_MEND: begin
          lenreg  <= 64'(msg_total) << 3;
          fin_ret <= S_SAVEIN;
          state   <= S_F80;
        end
        S_SAVEIN: begin
          inner <= hash;
          outer <= 1'b1;
          state <= S_PADINIT;
        end
        S_INNER: begin
          if (sctrl.push) begin
            cnt <= cnt + 1'b1;
            if (cnt == 6'(DIGEST_BYTES - 1)) begin
              lenreg  <= 64'(BLOCK_BYTES + DIGEST_BYTES) << 3;
              fin_ret <= S_EMIT;
              state   <= S_F80;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || pop) begin
            digest_word     <= hash[cnt[2:0]];
            word_index      <= cnt[2:0];
            last_word       <= cnt == 6'(DIGEST_WORDS - 1);
            length_overflow <= ovf;
            out_valid       <= 1'b1;
            cnt             <= cnt + 1'b1;
            if (cnt == 6'(DIGEST_WORDS - 1)) begin
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          for (int i = 0; i < 16; i++) begin
            key_w[i] <= '0;
          end
          plen      <= '0;
          hashed    <= 1'b0;
          ovf       <= 1'b0;
          key_phase <= 1'b1;
          outer     <= 1'b0;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/hs_checker.sv =====
// hs_checker: port-level assertions on the digest output of the engine,
// bound to hmac_sha1_engine. Depends on hs_pkg.
module hs_checker import hs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word,
  input logic        length_overflow
);

  localparam logic [2:0] LAST_IDX = 3'(DIGEST_WORDS - 1);

  logic [2:0] exp_idx;
  logic       ovf_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx  <= '0;
      ovf_hold <= 1'b0;
    end else if (pop && !empty) begin
      exp_idx <= last_word ? '0 : exp_idx + 1'b1;
      if (word_index == '0) begin
        ovf_hold <= length_overflow;
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_word == (word_index == LAST_IDX)))
    else $error("last_word does not match word_index");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (word_index == exp_idx))
    else $error("digest word out of order");

  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    (!empty && word_index != '0) |-> (length_overflow == ovf_hold))
    else $error("length_overflow changed within one digest");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(digest_word)))
    else $error("waiting result changed");

endmodule

bind hmac_sha1_engine hs_checker u_hs_checker (
  .clk             (clk),
  .rst             (rst),
  .empty           (empty),
  .pop             (pop),
  .digest_word     (digest_word),
  .word_index      (word_index),
  .last_word       (last_word),
  .length_overflow (length_overflow)
);

// ===== verif/hmac_sha1_engine_test.sv =====
// hmac_sha1_engine_test: self-checking bench for the streaming HMAC-SHA1 engine.
// Depends on hs_pkg and the RTL top hmac_sha1_engine; an in-bench SHA-1/HMAC
// calculator predicts every digest word, which is checked in arrival order.
module hmac_sha1_engine_test;
  import hs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_KEY = 1'b0;
  localparam logic CMD_MSG = 1'b1;
  localparam int   CYCLE_LIMIT = 3000000;
  localparam longint PART_LIMIT = (longint'(1) << LENGTH_BITS_DEF) - 1;

  typedef struct {
    word_t      dword;
    logic [2:0] idx;
    logic       lastw;
    logic       ovf;
  } digest_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic cmd = 1'b0;
  logic [7:0] data_byte = 8'd0;
  logic byte_valid = 1'b0;
  logic last_of_part = 1'b0;
  logic pop = 1'b0;
  logic full, empty, last_word, length_overflow;
  logic [31:0] digest_word;
  logic [2:0] word_index;

  hmac_sha1_engine dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd(cmd),
    .data_byte(data_byte), .byte_valid(byte_valid), .last_of_part(last_of_part),
    .empty(empty), .pop(pop), .digest_word(digest_word), .word_index(word_index),
    .last_word(last_word), .length_overflow(length_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  key_bytes[$];
  logic [7:0]  msg_bytes[$];
  logic        in_msg = 1'b0;
  logic        pred_ovf = 1'b0;
  digest_word_t expected_words[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int cycle_count = 0;
  int errors = 0;

  function automatic word_t rol(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic digest_t sha1_of(logic [7:0] m[$]);
    digest_t h;
    logic [7:0] p[$];
    logic [63:0] bits;
    word_t w[16];
    word_t a, b, c, d, e, f, k, t2;
    h = SHA_IV;
    p = m;
    bits = 64'(m.size()) << 3;
    p.push_back(PAD_MARK);
    while (p.size() % 64 != 56) p.push_back(8'h00);
    for (int i = 7; i >= 0; i--) p.push_back(bits[8*i +: 8]);
    for (int blk = 0; blk < p.size() / 64; blk++) begin
      for (int t = 0; t < 16; t++)
        w[t] = {p[blk*64+4*t], p[blk*64+4*t+1], p[blk*64+4*t+2], p[blk*64+4*t+3]};
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
      for (int t = 0; t < 80; t++) begin
        if (t >= 16) w[t%16] = rol(w[(t-3)%16] ^ w[(t-8)%16] ^ w[(t-14)%16] ^ w[t%16], 1);
        if (t < 20) begin f = (b & c) | (~b & d); k = K0; end
        else if (t < 40) begin f = b ^ c ^ d; k = K1; end
        else if (t < 60) begin f = (b & c) | (b & d) | (c & d); k = K2; end
        else begin f = b ^ c ^ d; k = K3; end
        t2 = rol(a, 5) + f + e + k + w[t%16];
        e = d; d = c; c = rol(b, 30); b = a; a = t2;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    end
    return h;
  endfunction

  function automatic void hmac_words();
    logic [7:0] kb[$];
    logic [7:0] inner[$];
    logic [7:0] outer[$];
    digest_t hd;
    digest_word_t r;
    kb = key_bytes;
    if (kb.size() > BLOCK_BYTES) begin
      hd = sha1_of(kb);
      kb = {};
      for (int i = 0; i < DIGEST_BYTES; i++) kb.push_back(byte_of(hd[i/4], 2'(i%4)));
    end
    while (kb.size() < BLOCK_BYTES) kb.push_back(8'h00);
    foreach (kb[i]) inner.push_back(kb[i] ^ IPAD);
    foreach (msg_bytes[i]) inner.push_back(msg_bytes[i]);
    hd = sha1_of(inner);
    foreach (kb[i]) outer.push_back(kb[i] ^ OPAD);
    for (int i = 0; i < DIGEST_BYTES; i++) outer.push_back(byte_of(hd[i/4], 2'(i%4)));
    hd = sha1_of(outer);
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      r.dword = hd[i];
      r.idx = 3'(i);
      r.lastw = (i == DIGEST_WORDS - 1);
      r.ovf = pred_ovf;
      expected_words.push_back(r);
    end
    key_bytes = {};
    msg_bytes = {};
    in_msg = 1'b0;
    pred_ovf = 1'b0;
  endfunction

  function automatic void predict(logic c, logic [7:0] d, logic v, logic l);
    if (!in_msg && c == CMD_KEY) begin
      if (v) begin
        if (key_bytes.size() >= PART_LIMIT) pred_ovf = 1'b1;
        else key_bytes.push_back(d);
      end
      if (l) in_msg = 1'b1;
      return;
    end
    if (in_msg && c == CMD_KEY) return;
    in_msg = 1'b1;
    if (v) begin
      if (msg_bytes.size() >= PART_LIMIT) pred_ovf = 1'b1;
      else msg_bytes.push_back(d);
    end
    if (l) hmac_words();
  endfunction

  task automatic send_word(logic c, logic [7:0] d, logic v, logic l);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    data_byte <= d;
    byte_valid <= v;
    last_of_part <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    predict(c, d, v, l);
    @(negedge clk);
  endtask

  task automatic send_key(int n);
    for (int i = 0; i < n; i++) send_word(CMD_KEY, 8'($urandom), 1'b1, i == n - 1);
  endtask

  task automatic send_msg(int n);
    for (int i = 0; i < n; i++) send_word(CMD_MSG, 8'($urandom), 1'b1, i == n - 1);
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic test_directed();
    send_word(CMD_KEY, 8'h00, 1'b0, 1'b1);
    send_word(CMD_MSG, 8'h00, 1'b0, 1'b1);
    send_word(CMD_KEY, 8'hff, 1'b1, 1'b0);
    send_word(CMD_KEY, 8'h00, 1'b0, 1'b0);
    send_word(CMD_KEY, 8'h55, 1'b1, 1'b1);
    send_word(CMD_MSG, 8'haa, 1'b1, 1'b0);
    send_word(CMD_KEY, 8'h12, 1'b1, 1'b1);
    send_word(CMD_MSG, 8'h00, 1'b0, 1'b0);
    send_word(CMD_MSG, 8'hff, 1'b1, 1'b1);
    send_word(CMD_KEY, 8'h01, 1'b1, 1'b0);
    send_word(CMD_MSG, 8'h80, 1'b1, 1'b1);
    send_word(CMD_MSG, 8'h7f, 1'b1, 1'b0);
    send_word(CMD_MSG, 8'h00, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_block_edges();
    send_key(65); send_msg(56);
    wait_drain();
  endtask

  task automatic test_random(int items);
    int sent;
    int nk, nm;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        send_word(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        nk = $urandom_range(0, 6);
        nm = $urandom_range(0, 6);
        if (nk == 0) send_word(CMD_KEY, 8'($urandom), 1'b0, 1'b1);
        else send_key(nk);
        if (nm == 0) send_word(CMD_MSG, 8'($urandom), 1'b0, 1'b1);
        else send_msg(nm);
        sent += nk + nm + 2;
      end
    end
    send_word(CMD_MSG, 8'h00, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 3000;
    send_key(1); send_msg(1);
    send_key(2); send_msg(2);
    send_key(1); send_msg(1);
    wait_drain();
  endtask

  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $error("unexpected digest word %h", digest_word);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (digest_word !== exp_w.dword) begin
          $error("digest_word exp %h got %h", exp_w.dword, digest_word); errors++;
        end
        if (word_index !== exp_w.idx) begin
          $error("word_index exp %0d got %0d", exp_w.idx, word_index); errors++;
        end
        if (last_word !== exp_w.lastw) begin
          $error("last_word exp %0d got %0d", exp_w.lastw, last_word); errors++;
        end
        if (length_overflow !== exp_w.ovf) begin
          $error("length_overflow exp %0d got %0d", exp_w.ovf, length_overflow); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_block_edges();
    test_backpressure();
    test_random(4);
    send_idle_pct = 61;
    test_random(4);
    send_idle_pct = 0; recv_stall_pct = 61;
    test_random(4);
    send_idle_pct = 28; recv_stall_pct = 28;
    test_random(4);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (expected_words.size() != 0) $error("%0d digest words never arrived", expected_words.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
